// ===== design/lmde_pkg.sv =====
// ----------------------------------------------------------------------------
// lmde_pkg
// Shared widths, register indexes and defaults for the label map
// dilate / erode block.
// ----------------------------------------------------------------------------
package lmde_pkg;

  localparam int DEF_MAX_ROWS   = 512;
  localparam int DEF_MAX_COLS   = 512;
  localparam int DEF_LABEL_BITS = 4;

  // item and register field widths
  localparam int COORD_W  = 9;
  localparam int LABEL_W  = 4;
  localparam int RADIUS_W = 4;
  localparam int NLAB_W   = 5;
  localparam int GEOM_W   = 10;

  // largest window and its pixel count width
  localparam int RAD_MAX  = (1 << RADIUS_W) - 1;
  localparam int WIN_MAX  = (2 * RAD_MAX + 1) * (2 * RAD_MAX + 1);
  localparam int CNT_W    = $clog2(WIN_MAX + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GEOM_W;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LABEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LABELS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd6;

  localparam logic               MODE_DILATE = 1'b0;
  localparam logic               KIND_WRITE  = 1'b0;
  localparam logic [NLAB_W-1:0]  NUM_LABELS_RST   = 5'd4;
  localparam logic [GEOM_W-1:0]  IMAGE_HEIGHT_RST = 10'd512;
  localparam logic [GEOM_W-1:0]  IMAGE_WIDTH_RST  = 10'd512;

endpackage

// ===== design/lmde_if.sv =====
// ----------------------------------------------------------------------------
// lmde_if
// Channel interfaces: request items, result items and register writes.
// ----------------------------------------------------------------------------
interface lmde_req_if;
  import lmde_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [LABEL_W-1:0] label_in;
  modport source(output valid, kind, row, col, label_in, input ready);
  modport sink(input valid, kind, row, col, label_in, output ready);
endinterface

interface lmde_rsp_if;
  import lmde_pkg::*;
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label_out;
  logic               changed;
  modport source(output valid, label_out, changed, input ready);
  modport sink(input valid, label_out, changed, output ready);
endinterface

interface lmde_cfg_if;
  import lmde_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/label_map_dilate_erode.sv =====
// ----------------------------------------------------------------------------
// label_map_dilate_erode
// Label image store with a windowed dilate / erode query. Write beats fill
// the store; a compute beat scans its clipped window through one memory port.
// ----------------------------------------------------------------------------
// Write beat: the label is stored when the item is taken. Compute beat: the
// own pixel is read, then the window pixel by pixel (one read port); in erode
// mode, when the own pixel holds the target label, a vote scan follows.
// One item at a time; a finished result waits in the output register.
// Reset (rst, synchronous) clears control state and loads the configuration
// defaults; the label store has no reset and holds undefined data until written.
module label_map_dilate_erode #(
  parameter int MAX_ROWS   = lmde_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = lmde_pkg::DEF_MAX_COLS,
  parameter int LABEL_BITS = lmde_pkg::DEF_LABEL_BITS
) (
  input  logic       clk,
  input  logic       rst,
  lmde_req_if.sink   req,
  lmde_rsp_if.source rsp,
  lmde_cfg_if.sink   cfg
);
  import lmde_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int NUM_CNT = (LABEL_BITS < LABEL_W) ? (1 << LABEL_BITS) : (1 << LABEL_W);
  localparam int CIDX_W  = $clog2(NUM_CNT);
  localparam int SCAN_W  = $clog2(NUM_CNT + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_OWN   = 6'b000010,
    S_WIN   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic                op_mode;
  logic [LABEL_W-1:0]  target_label;
  logic [RADIUS_W-1:0] vert_radius;
  logic [RADIUS_W-1:0] horiz_radius;
  logic [NLAB_W-1:0]   num_labels;
  logic [GEOM_W-1:0]   image_height;
  logic [GEOM_W-1:0]   image_width;

  // item context
  logic [COORD_W-1:0]    row_q, col_q;
  logic [GEOM_W-1:0]     r, c, c0, r1, c1;
  logic                  in_image, own_ok;
  logic                  tag_own, tag_win;
  logic [LABEL_BITS-1:0] own, best, res_q;
  logic                  hit;
  logic [CNT_W-1:0]      best_n;
  logic [CNT_W-1:0]      counts [NUM_CNT];
  logic [SCAN_W-1:0]     scan;

  // output register
  logic                  out_valid;
  logic [LABEL_W-1:0]    out_label;
  logic                  out_changed;

  // label store
  logic [LABEL_BITS-1:0] mem [DEPTH];
  logic [LABEL_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [GEOM_W-1:0]     rd_row, rd_col;
  logic                  wr_en;

  logic                  req_take, out_load, last_px;
  logic [LABEL_BITS-1:0] tgt;
  logic [GEOM_W-1:0]     h, w, row_e, col_e, r0_s, r1_s, c0_s, c1_s;
  logic [SCAN_W-1:0]     scan_lim;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.label_out = out_label;
  assign rsp.changed   = out_changed;

  assign req_take = req.valid && (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);
  assign last_px  = (r == r1) && (c == c1);

  assign tgt = LABEL_BITS'(target_label);
  assign h = (32'(image_height) > MAX_ROWS) ? GEOM_W'(MAX_ROWS) : image_height;
  assign w = (32'(image_width) > MAX_COLS) ? GEOM_W'(MAX_COLS) : image_width;
  assign scan_lim = (32'(num_labels) > NUM_CNT) ? SCAN_W'(NUM_CNT) : SCAN_W'(num_labels);

  // window bounds, clipped at the image edges
  assign row_e = GEOM_W'(row_q);
  assign col_e = GEOM_W'(col_q);
  assign r0_s  = (row_e >= GEOM_W'(vert_radius)) ? row_e - GEOM_W'(vert_radius) : '0;
  assign c0_s  = (col_e >= GEOM_W'(horiz_radius)) ? col_e - GEOM_W'(horiz_radius) : '0;
  assign r1_s  = (row_e + GEOM_W'(vert_radius) > h - 1'b1) ? h - 1'b1
                                                           : row_e + GEOM_W'(vert_radius);
  assign c1_s  = (col_e + GEOM_W'(horiz_radius) > w - 1'b1) ? w - 1'b1
                                                            : col_e + GEOM_W'(horiz_radius);

  // memory addressing
  assign wr_en   = req_take && (req.kind == KIND_WRITE) &&
                   (32'(req.row) < MAX_ROWS) && (32'(req.col) < MAX_COLS);
  assign wr_addr = ADDR_W'(32'(req.row) * MAX_COLS + 32'(req.col));
  assign rd_row  = (state == S_OWN) ? row_e : r;
  assign rd_col  = (state == S_OWN) ? col_e : c;
  assign rd_addr = ADDR_W'(32'(rd_row) * MAX_COLS + 32'(rd_col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= LABEL_BITS'(req.label_in);
    end
    rd_data <= mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode      <= MODE_DILATE;
      target_label <= '0;
      vert_radius  <= '0;
      horiz_radius <= '0;
      num_labels   <= NUM_LABELS_RST;
      image_height <= IMAGE_HEIGHT_RST;
      image_width  <= IMAGE_WIDTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OP_MODE:      op_mode      <= cfg.data[0];
        REG_TARGET_LABEL: target_label <= cfg.data[LABEL_W-1:0];
        REG_VERT_RADIUS:  vert_radius  <= cfg.data[RADIUS_W-1:0];
        REG_HORIZ_RADIUS: horiz_radius <= cfg.data[RADIUS_W-1:0];
        REG_NUM_LABELS:   num_labels   <= cfg.data[NLAB_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[GEOM_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_take && req.kind != KIND_WRITE) state_next = S_OWN;
      end
      S_OWN: begin
        state_next = ((row_e < h) && (col_e < w)) ? S_WIN : S_DRAIN;
      end
      S_WIN: begin
        if (last_px) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!tag_own && !tag_win) begin
          state_next = (in_image && op_mode != MODE_DILATE && own == tgt) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan >= scan_lim) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tag_own <= 1'b0;
      tag_win <= 1'b0;
    end else begin
      state   <= state_next;
      tag_own <= (state == S_OWN);
      tag_win <= (state == S_WIN);
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (req_take) begin
      row_q <= req.row;
      col_q <= req.col;
    end

    if (state == S_OWN) begin
      in_image <= (row_e < h) && (col_e < w);
      own_ok   <= (32'(row_q) < MAX_ROWS) && (32'(col_q) < MAX_COLS);
      r        <= r0_s;
      c        <= c0_s;
      c0       <= c0_s;
      r1       <= r1_s;
      c1       <= c1_s;
      hit      <= 1'b0;
    end else if (state == S_WIN) begin
      if (c == c1) begin
        c <= c0;
        r <= r + 1'b1;
      end else begin
        c <= c + 1'b1;
      end
    end

    if (tag_own) begin
      own <= own_ok ? rd_data : '0;
    end
    if (tag_win && rd_data == tgt) begin
      hit <= 1'b1;
    end

    for (int i = 0; i < NUM_CNT; i++) begin
      if (state == S_OWN) begin
        counts[i] <= '0;
      end else if (tag_win && rd_data != tgt && 32'(rd_data) == i &&
                   32'(rd_data) < 32'(num_labels)) begin
        counts[i] <= counts[i] + 1'b1;
      end
    end

    if (state == S_DRAIN) begin
      scan   <= '0;
      best   <= tgt;
      best_n <= '0;
      res_q  <= (in_image && op_mode == MODE_DILATE && hit) ? tgt : own;
    end else if (state == S_SCAN) begin
      if (scan < scan_lim) begin
        if (counts[scan[CIDX_W-1:0]] > best_n) begin
          best_n <= counts[scan[CIDX_W-1:0]];
          best   <= LABEL_BITS'(scan);
        end
        scan <= scan + 1'b1;
      end else begin
        res_q <= best;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_label   <= LABEL_W'(res_q);
      out_changed <= (res_q != own);
    end
  end

endmodule
